@@ src/ght_pkg.sv @@
// Shared types and constants of the generational handle table.
`default_nettype none

package ght_pkg;

  localparam int unsigned DefCapacity = 1024;

  localparam int unsigned OpW       = 2;
  localparam int unsigned HandleW   = 16;
  localparam int unsigned GenW      = 16;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned OutIdW    = 10;
  localparam int unsigned OutPosW   = 10;
  localparam int unsigned OutCountW = 11;

  typedef enum logic [OpW-1:0] {
    OP_ALLOC  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_STALE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_RD3,
    S_WR
  } ctrl_state_e;

  typedef struct packed {
    logic [OpW-1:0]     op;
    logic [HandleW-1:0] handle_id;
    logic [GenW-1:0]    handle_generation;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [OutIdW-1:0]    out_id;
    logic [GenW-1:0]      out_generation;
    logic [OutPosW-1:0]   dense_position;
    logic [OutCountW-1:0] live_count;
  } rsp_t;

endpackage

`default_nettype wire

@@ src/ght_ifs.sv @@
// Request and response channel interfaces of the handle table.
`default_nettype none

interface ght_req_if;
  import ght_pkg::*;

  logic               valid;
  logic               ready;
  logic [OpW-1:0]     op;
  logic [HandleW-1:0] handle_id;
  logic [GenW-1:0]    handle_generation;

  modport source (output valid, output op, output handle_id, output handle_generation,
                  input ready);
  modport sink (input valid, input op, input handle_id, input handle_generation,
                output ready);
endinterface

interface ght_rsp_if;
  import ght_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [StatusW-1:0]   status;
  logic [OutIdW-1:0]    out_id;
  logic [GenW-1:0]      out_generation;
  logic [OutPosW-1:0]   dense_position;
  logic [OutCountW-1:0] live_count;

  modport source (output valid, output status, output out_id, output out_generation,
                  output dense_position, output live_count, input ready);
  modport sink (input valid, input status, input out_id, input out_generation,
                input dense_position, input live_count, output ready);
endinterface

`default_nettype wire

@@ src/ght_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ght_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output      logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // The read data holds until the next read, so a stalled consumer keeps it.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/ght_ctrl.sv @@
// Sequencer that reads, checks and rewrites the offset map and slot store.
`default_nettype none

module ght_ctrl #(
  parameter int unsigned Capacity = ght_pkg::DefCapacity,
  localparam int unsigned AddrW = $clog2(Capacity),
  localparam int unsigned CntW  = $clog2(Capacity + 1),
  localparam int unsigned SlotW = ght_pkg::GenW + AddrW
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  output      logic             req_ready_o,
  input  wire ght_pkg::req_t    req_i,
  input  wire logic             out_free_i,
  output      logic             res_valid_o,
  output      ght_pkg::rsp_t    res_o,
  output      logic             off_we_o,
  output      logic [AddrW-1:0] off_waddr_o,
  output      logic [AddrW-1:0] off_wdata_o,
  output      logic             off_re_o,
  output      logic [AddrW-1:0] off_raddr_o,
  input  wire logic [AddrW-1:0] off_rdata_i,
  output      logic             slot_we_o,
  output      logic [AddrW-1:0] slot_waddr_o,
  output      logic [SlotW-1:0] slot_wdata_o,
  output      logic             slot_re_o,
  output      logic [AddrW-1:0] slot_raddr_o,
  input  wire logic [SlotW-1:0] slot_rdata_i
);
  import ght_pkg::*;

  ctrl_state_e        state_q, state_d;
  logic [OpW-1:0]     op_q;
  logic [HandleW-1:0] id_q;
  logic [GenW-1:0]    gen_q;
  logic [AddrW-1:0]   pos_q, pos_d;
  logic [AddrW-1:0]   off_ra_q, slot_ra_q;
  logic [CntW-1:0]    live_q, live_d;
  logic [CntW-1:0]    hw_q, hw_d;

  logic               off_unwr, slot_unwr;
  logic [AddrW-1:0]   off_pos;
  logic [GenW-1:0]    slot_gen;
  logic [AddrW-1:0]   slot_id;
  logic [AddrW-1:0]   last;
  logic [GenW-1:0]    gen_inc;
  logic               id_in_range, pos_live, live_zero, is_full;
  logic               find_go, match;

  // Entries at or above the high-water mark were never written and read as
  // their reset value: the identity map and generation zero.
  assign off_unwr  = CntW'(off_ra_q) >= hw_q;
  assign slot_unwr = CntW'(slot_ra_q) >= hw_q;
  assign off_pos   = off_unwr ? off_ra_q : off_rdata_i;
  assign slot_gen  = slot_unwr ? '0 : slot_rdata_i[SlotW-1:AddrW];
  assign slot_id   = slot_unwr ? slot_ra_q : slot_rdata_i[AddrW-1:0];

  assign last        = AddrW'(live_q - CntW'(1));
  assign gen_inc     = gen_q + GenW'(1);
  assign id_in_range = {1'b0, id_q} < (HandleW + 1)'(Capacity);
  assign pos_live    = CntW'(off_pos) < live_q;
  assign live_zero   = live_q == '0;
  assign is_full     = live_q == CntW'(Capacity);
  assign find_go     = (op_q == OP_LOOKUP || (op_q == OP_DELETE && !live_zero)) &&
                       id_in_range && pos_live;
  assign match       = slot_gen == gen_q && HandleW'(slot_id) == id_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = S_RD1;
        end
      end
      S_RD1: begin
        if (op_q != OP_ALLOC && find_go) begin
          state_d = S_RD2;
        end else if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      S_RD2: begin
        if (match && op_q == OP_DELETE) begin
          state_d = S_RD3;
        end else if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      S_RD3: begin
        state_d = S_WR;
      end
      S_WR: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready_o  = 1'b0;
    res_valid_o  = 1'b0;
    res_o        = '0;
    off_we_o     = 1'b0;
    off_waddr_o  = '0;
    off_wdata_o  = '0;
    off_re_o     = 1'b0;
    off_raddr_o  = '0;
    slot_we_o    = 1'b0;
    slot_waddr_o = '0;
    slot_wdata_o = '0;
    slot_re_o    = 1'b0;
    slot_raddr_o = '0;
    pos_d        = pos_q;
    live_d       = live_q;
    hw_d         = hw_q;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          off_re_o     = 1'b1;
          off_raddr_o  = req_i.handle_id[AddrW-1:0];
          slot_re_o    = 1'b1;
          slot_raddr_o = live_q[AddrW-1:0];
        end
      end
      S_RD1: begin
        if (op_q == OP_ALLOC) begin
          res_valid_o = 1'b1;
          if (is_full) begin
            res_o.status     = ST_FULL;
            res_o.live_count = OutCountW'(live_q);
          end else begin
            res_o.status         = ST_OK;
            res_o.out_id         = OutIdW'(slot_id);
            res_o.out_generation = slot_gen;
            res_o.dense_position = OutPosW'(slot_ra_q);
            res_o.live_count     = OutCountW'(live_q + CntW'(1));
            if (out_free_i) begin
              live_d = live_q + CntW'(1);
              // A fresh slot gets its reset contents written as it goes live.
              if (slot_unwr) begin
                hw_d         = hw_q + CntW'(1);
                slot_we_o    = 1'b1;
                slot_waddr_o = slot_ra_q;
                slot_wdata_o = {GenW'(0), slot_ra_q};
                off_we_o     = 1'b1;
                off_waddr_o  = slot_ra_q;
                off_wdata_o  = slot_ra_q;
              end
            end
          end
        end else begin
          pos_d = off_pos;
          if (find_go) begin
            slot_re_o    = 1'b1;
            slot_raddr_o = off_pos;
          end else begin
            res_valid_o      = 1'b1;
            res_o.status     = (op_q == OP_DELETE && live_zero) ? ST_EMPTY : ST_STALE;
            res_o.live_count = OutCountW'(live_q);
          end
        end
      end
      S_RD2: begin
        if (match && op_q == OP_DELETE) begin
          slot_re_o    = 1'b1;
          slot_raddr_o = last;
        end else begin
          res_valid_o      = 1'b1;
          res_o.live_count = OutCountW'(live_q);
          if (match) begin
            res_o.status         = ST_OK;
            res_o.out_id         = OutIdW'(id_q);
            res_o.out_generation = gen_q;
            res_o.dense_position = OutPosW'(pos_q);
          end else begin
            res_o.status = ST_STALE;
          end
        end
      end
      S_RD3: begin
        // The last live slot moves down into the hole; its id remaps there.
        slot_we_o    = 1'b1;
        slot_waddr_o = pos_q;
        slot_wdata_o = (pos_q == last) ? {gen_inc, id_q[AddrW-1:0]} : {slot_gen, slot_id};
        off_we_o     = pos_q != last;
        off_waddr_o  = slot_id;
        off_wdata_o  = pos_q;
      end
      S_WR: begin
        res_valid_o          = 1'b1;
        res_o.status         = ST_OK;
        res_o.out_id         = OutIdW'(id_q);
        res_o.out_generation = gen_q;
        res_o.dense_position = OutPosW'(pos_q);
        res_o.live_count     = OutCountW'(live_q - CntW'(1));
        if (out_free_i) begin
          live_d = live_q - CntW'(1);
          if (pos_q != last) begin
            slot_we_o    = 1'b1;
            slot_waddr_o = last;
            slot_wdata_o = {gen_inc, id_q[AddrW-1:0]};
            off_we_o     = 1'b1;
            off_waddr_o  = id_q[AddrW-1:0];
            off_wdata_o  = last;
          end
        end
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      live_q  <= '0;
      hw_q    <= '0;
    end else begin
      state_q <= state_d;
      live_q  <= live_d;
      hw_q    <= hw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (req_valid_i && req_ready_o) begin
      op_q  <= req_i.op;
      id_q  <= req_i.handle_id;
      gen_q <= req_i.handle_generation;
    end
    if (off_re_o) begin
      off_ra_q <= off_raddr_o;
    end
    if (slot_re_o) begin
      slot_ra_q <= slot_raddr_o;
    end
  end

`ifndef SYNTHESIS
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CntW'(Capacity) && live_q <= hw_q)
    else $error("live count exceeds capacity or high-water mark");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !(slot_we_o || off_we_o))
    else $error("memory written while idle");

  a_alloc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD1 && op_q == OP_ALLOC && out_free_i && !is_full)
    |=> live_q == CntW'($past(live_q) + CntW'(1)))
    else $error("allocate did not grow the live count");

  a_del_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR && out_free_i) |=> live_q == CntW'($past(live_q) - CntW'(1)))
    else $error("delete did not shrink the live count");

  a_del_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD3 |=> state_q == S_WR)
    else $error("swap write not followed by its second half");
`endif

endmodule

`default_nettype wire

@@ src/generational_handle_table.sv @@
// Top level of the generational handle table.
// Handle table with generation counters over CAPACITY slots. Each request
// item carries op (allocate, lookup, delete) and a handle, and yields exactly
// one response item with status, handle, dense position and live count.
// The offset map and the slot store live in two synchronous RAMs, and the
// slot store has a single read port, so items are worked one at a time:
// allocate answers from the slot read made at acceptance; lookup reads the
// offset map, then the slot; delete adds a read of the last live slot and a
// swap write-back in two steps, the second also giving the response to the
// output register. That register lets the next item be accepted while a
// response waits. No clearing pass follows reset: a high-water mark of
// ever-used slots makes untouched entries read as their reset values, so
// the block is ready as soon as reset ends.
`default_nettype none

module generational_handle_table #(
  parameter int unsigned Capacity = ght_pkg::DefCapacity
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  ght_req_if.sink   req_i,
  ght_rsp_if.source rsp_o
);
  import ght_pkg::*;

  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned SlotW = GenW + AddrW;

  req_t             req;
  rsp_t             res;
  logic             res_valid;
  logic             out_free;
  logic             out_valid_q;
  rsp_t             out_q;

  logic             off_we, off_re;
  logic [AddrW-1:0] off_waddr, off_wdata, off_raddr, off_rdata;
  logic             slot_we, slot_re;
  logic [AddrW-1:0] slot_waddr, slot_raddr;
  logic [SlotW-1:0] slot_wdata, slot_rdata;

  assign req.op                = req_i.op;
  assign req.handle_id         = req_i.handle_id;
  assign req.handle_generation = req_i.handle_generation;

  assign out_free = !out_valid_q || rsp_o.ready;

  ght_ctrl #(
    .Capacity (Capacity)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (req_i.ready),
    .req_i        (req),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .off_we_o     (off_we),
    .off_waddr_o  (off_waddr),
    .off_wdata_o  (off_wdata),
    .off_re_o     (off_re),
    .off_raddr_o  (off_raddr),
    .off_rdata_i  (off_rdata),
    .slot_we_o    (slot_we),
    .slot_waddr_o (slot_waddr),
    .slot_wdata_o (slot_wdata),
    .slot_re_o    (slot_re),
    .slot_raddr_o (slot_raddr),
    .slot_rdata_i (slot_rdata)
  );

  ght_ram #(
    .Width (AddrW),
    .Depth (Capacity)
  ) u_offset_ram (
    .clk_i   (clk_i),
    .we_i    (off_we),
    .waddr_i (off_waddr),
    .wdata_i (off_wdata),
    .re_i    (off_re),
    .raddr_i (off_raddr),
    .rdata_o (off_rdata)
  );

  ght_ram #(
    .Width (SlotW),
    .Depth (Capacity)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_q.status;
  assign rsp_o.out_id         = out_q.out_id;
  assign rsp_o.out_generation = out_q.out_generation;
  assign rsp_o.dense_position = out_q.dense_position;
  assign rsp_o.live_count     = out_q.live_count;

endmodule

`default_nettype wire

@@ tb/generational_handle_table_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the generational handle table.

module generational_handle_table_tb;
  import ght_pkg::*;

  localparam int unsigned Cap         = DefCapacity;
  localparam int unsigned RandomItems = 1050;
  localparam int unsigned SweepPairs  = 4;
  localparam int unsigned CycleLimit  = 4000000;
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;

  ght_req_if req_if ();
  ght_rsp_if rsp_if ();

  generational_handle_table #(
    .Capacity(Cap)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted contents of the table.
  logic [OutPosW-1:0]   tbl_offset[Cap];
  logic [OutIdW-1:0]    tbl_id[Cap];
  logic [GenW-1:0]      tbl_gen[Cap];
  logic [OutCountW-1:0] tbl_live;

  req_t        req_q[$];
  rsp_t        awaited_rsp[$];
  req_t        next_req;
  rsp_t        want_rsp;
  int          burst_left;
  int          gap_left;
  logic [7:0]  ready_pat;
  int unsigned pat_age;
  bit          no_idling;
  int unsigned err_count;
  int unsigned rsp_count;
  int unsigned cycle_count;

  function automatic rsp_t apply_table_op(logic [OpW-1:0] op, logic [HandleW-1:0] hid,
                                          logic [GenW-1:0] hgen);
    rsp_t                 r;
    int unsigned          pos;
    int unsigned          last;
    logic [OutIdW-1:0]    moved_id;
    logic [GenW-1:0]      moved_gen;
    bit                   hit;
    r = '0;
    r.status = ST_STALE;
    pos = 0;
    hit = 1'b0;
    if (hid < Cap) begin
      pos = tbl_offset[hid];
      hit = (pos < tbl_live) && (tbl_gen[pos] == hgen) && (tbl_id[pos] == hid);
    end
    case (op)
      OP_ALLOC: begin
        if (tbl_live >= Cap) begin
          r.status = ST_FULL;
        end else begin
          r.status = ST_OK;
          r.dense_position = tbl_live[OutPosW-1:0];
          r.out_id = tbl_id[tbl_live];
          r.out_generation = tbl_gen[tbl_live];
          tbl_live = tbl_live + 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          r.status = ST_OK;
          r.out_id = hid[OutIdW-1:0];
          r.out_generation = hgen;
          r.dense_position = pos[OutPosW-1:0];
        end
      end
      OP_DELETE: begin
        if (tbl_live == 0) begin
          r.status = ST_EMPTY;
        end else if (hit) begin
          r.status = ST_OK;
          r.out_id = hid[OutIdW-1:0];
          r.out_generation = hgen;
          r.dense_position = pos[OutPosW-1:0];
          last = tbl_live - 1;
          tbl_gen[pos] = hgen + 16'd1;
          // The last live slot moves into the hole so live slots stay packed.
          if (pos != last) begin
            moved_id = tbl_id[last];
            moved_gen = tbl_gen[last];
            tbl_offset[moved_id] = pos[OutPosW-1:0];
            tbl_offset[hid] = last[OutPosW-1:0];
            tbl_id[last] = tbl_id[pos];
            tbl_gen[last] = tbl_gen[pos];
            tbl_id[pos] = moved_id;
            tbl_gen[pos] = moved_gen;
          end
          tbl_live = last[OutCountW-1:0];
        end
      end
      default: r.status = ST_STALE;
    endcase
    r.live_count = tbl_live;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: response %0d %s: got %0h, expected %0h", $time, rsp_count, what, got, want);
    err_count++;
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.op <= '0;
      req_if.handle_id <= '0;
      req_if.handle_generation <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        awaited_rsp.push_back(apply_table_op(req_if.op, req_if.handle_id,
                                             req_if.handle_generation));
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0 && !no_idling) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          next_req = req_q.pop_front();
          req_if.op <= next_req.op;
          req_if.handle_id <= next_req.handle_id;
          req_if.handle_generation <= next_req.handle_generation;
          req_if.valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: checks each item and stalls on a rotating pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (awaited_rsp.size() == 0) begin
          report_mismatch("arrived with nothing pending, status", rsp_if.status, 0);
        end else begin
          want_rsp = awaited_rsp.pop_front();
          if (rsp_if.status !== want_rsp.status)
            report_mismatch("status", rsp_if.status, want_rsp.status);
          if (rsp_if.out_id !== want_rsp.out_id)
            report_mismatch("out_id", rsp_if.out_id, want_rsp.out_id);
          if (rsp_if.out_generation !== want_rsp.out_generation)
            report_mismatch("out_generation", rsp_if.out_generation, want_rsp.out_generation);
          if (rsp_if.dense_position !== want_rsp.dense_position)
            report_mismatch("dense_position", rsp_if.dense_position, want_rsp.dense_position);
          if (rsp_if.live_count !== want_rsp.live_count)
            report_mismatch("live_count", rsp_if.live_count, want_rsp.live_count);
        end
        rsp_count++;
      end
      pat_age++;
      if (pat_age >= 32) begin
        pat_age = 0;
        ready_pat = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
      end else begin
        ready_pat = {ready_pat[0], ready_pat[7:1]};
      end
      rsp_if.ready <= no_idling ? 1'b1 : ready_pat[0];
    end
  end

  task automatic queue_req(logic [OpW-1:0] op, logic [HandleW-1:0] hid, logic [GenW-1:0] hgen);
    req_t item;
    item.op = op;
    item.handle_id = hid;
    item.handle_generation = hgen;
    while (req_q.size() >= 2) @(negedge clk_i);
    req_q.push_back(item);
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || req_if.valid || awaited_rsp.size() != 0) @(negedge clk_i);
  endtask

  // Picks a live handle of the predicted table, or any when none is live, so it usually hits.
  task automatic queue_live_handle(logic [OpW-1:0] op);
    int unsigned pos;
    if (tbl_live == 0) begin
      queue_req(op, 16'($urandom_range(Cap - 1)), 16'($urandom_range(3)));
    end else begin
      pos = $urandom_range(tbl_live - 1);
      queue_req(op, 16'(tbl_id[pos]), tbl_gen[pos]);
    end
  endtask

  task automatic queue_noise();
    int unsigned hid;
    int unsigned pos;
    case ($urandom_range(2))
      0: queue_req(OpW'($urandom), 16'($urandom), 16'($urandom));
      1: begin
        // In range with the stored generation; hits only if the slot is live.
        hid = $urandom_range(Cap - 1);
        queue_req($urandom_range(1) ? OP_LOOKUP : OP_DELETE, 16'(hid),
                  tbl_gen[tbl_offset[hid]]);
      end
      default: begin
        pos = (tbl_live == 0) ? 0 : $urandom_range(tbl_live - 1);
        queue_req($urandom_range(1) ? OP_LOOKUP : OP_DELETE, 16'(tbl_id[pos]),
                  tbl_gen[pos] ^ (16'd1 << $urandom_range(15)));
      end
    endcase
  endtask

  // Alternates between filling and draining the table; the first fill runs to full.
  task automatic run_random_mix();
    int unsigned n;
    int unsigned since_full;
    int unsigned full_hits;
    int unsigned roll;
    int unsigned high_mark;
    int unsigned low_mark;
    bit          seen_full;
    bit          climbing;
    n = 0;
    since_full = 0;
    full_hits = 0;
    seen_full = 1'b0;
    climbing = 1'b1;
    high_mark = Cap;
    low_mark = 0;
    while (!(n >= RandomItems && seen_full && since_full >= 32)) begin
      roll = $urandom_range(99);
      if (climbing) begin
        if (roll < 97) queue_req(OP_ALLOC, 16'($urandom), 16'($urandom));
        else if (roll < 98) queue_live_handle(OP_LOOKUP);
        else if (roll < 99) queue_live_handle(OP_DELETE);
        else queue_noise();
      end else begin
        if (roll < 70) queue_live_handle(OP_DELETE);
        else if (roll < 85) queue_live_handle(OP_LOOKUP);
        else if (roll < 93) queue_req(OP_ALLOC, 16'($urandom), 16'($urandom));
        else queue_noise();
      end
      n++;
      if (seen_full) since_full++;
      if (tbl_live == Cap) begin
        seen_full = 1'b1;
        full_hits++;
      end
      if (climbing && tbl_live >= high_mark && (high_mark < Cap || full_hits >= 6)) begin
        climbing = 1'b0;
        full_hits = 0;
        low_mark = $urandom_range(Cap / 2);
      end else if (!climbing && tbl_live <= low_mark) begin
        climbing = 1'b1;
        high_mark = $urandom_range(Cap / 2, Cap);
      end
    end
  endtask

  initial begin
    int unsigned   sweep_pos;
    logic [9:0]    sweep_id;
    logic [15:0]   sweep_gen;
    for (int unsigned i = 0; i < Cap; i++) begin
      tbl_offset[i] = OutPosW'(i);
      tbl_id[i] = OutIdW'(i);
      tbl_gen[i] = '0;
    end
    tbl_live = '0;
    err_count = 0;
    rsp_count = 0;
    burst_left = 1;
    gap_left = 0;
    ready_pat = 8'hFF;
    pat_age = 0;
    no_idling = 1'b0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.op = '0;
    req_if.handle_id = '0;
    req_if.handle_generation = '0;
    rsp_if.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty table, allocates, then stale, out-of-range and in-range not-live handles, and the unused op.
    queue_req(OP_DELETE, 16'd0, 16'd0);
    queue_req(OP_LOOKUP, 16'd0, 16'd0);
    queue_req(OpUnused, 16'hFFFF, 16'hFFFF);
    queue_req(OP_ALLOC, 16'hFFFF, 16'hFFFF);
    queue_req(OP_ALLOC, 16'd0, 16'd0);
    queue_req(OP_ALLOC, 16'd0, 16'd0);
    queue_req(OP_LOOKUP, 16'd1, 16'd0);
    queue_req(OP_LOOKUP, 16'd1, 16'd1);
    queue_req(OP_LOOKUP, 16'd2, 16'hFFFF);
    queue_req(OP_LOOKUP, 16'hFFFF, 16'd0);
    queue_req(OP_LOOKUP, 16'(Cap), 16'd0);
    queue_req(OP_DELETE, 16'(Cap), 16'd0);
    queue_req(OP_LOOKUP, 16'd3, 16'd0);
    // Delete from the front swaps in the last live slot.
    queue_req(OP_DELETE, 16'd0, 16'd0);
    queue_req(OP_DELETE, 16'd0, 16'd0);
    queue_req(OP_LOOKUP, 16'd0, 16'd1);
    queue_req(OP_LOOKUP, 16'd2, 16'd0);
    queue_req(OP_DELETE, 16'd1, 16'd0);
    queue_req(OP_DELETE, 16'd2, 16'd0);
    queue_req(OP_DELETE, 16'd2, 16'd1);
    queue_req(OP_ALLOC, 16'd0, 16'd0);
    queue_req(OpUnused, 16'd0, 16'd0);
    queue_req(OP_DELETE, 16'd2, 16'd1);
    queue_req(OP_ALLOC, 16'd0, 16'd0);

    // The sender holds off until every response is back.
    wait_drained();

    // Cycle one slot through a few generations with items back to back.
    no_idling = 1'b1;
    sweep_pos = tbl_live;
    sweep_id = tbl_id[sweep_pos];
    sweep_gen = tbl_gen[sweep_pos];
    for (int unsigned k = 0; k < SweepPairs; k++) begin
      queue_req(OP_ALLOC, 16'd0, 16'd0);
      queue_req(OP_DELETE, 16'(sweep_id), sweep_gen);
      sweep_gen = sweep_gen + 16'd1;
    end
    wait_drained();
    no_idling = 1'b0;

    run_random_mix();
    wait_drained();
    repeat (16) @(posedge clk_i);
    if (err_count == 0) begin
      $display("generational_handle_table test passed");
    end else begin
      $display("generational_handle_table test failed");
    end
    $finish;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: run exceeded %0d cycles", $time, CycleLimit);
    $display("generational_handle_table test failed");
    $finish;
  end

endmodule

@@ sim.f @@
src/ght_pkg.sv
src/ght_ifs.sv
src/ght_ram.sv
src/ght_ctrl.sv
src/generational_handle_table.sv
tb/generational_handle_table_tb.sv
